### sv/pisq_pkg.sv
// Package: shared types and constants for the positional insert search queue.
package pisq_pkg;

    // Default number of entries in the queue
    localparam int unsigned DEPTH_DEF = 16;

    // Field widths of the transfer payloads
    localparam int unsigned OP_W    = 2;
    localparam int unsigned POS_W   = 5;
    localparam int unsigned COORD_W = 32;
    localparam int unsigned WORD_W  = 2 * COORD_W;
    localparam int unsigned CNT_W   = 5;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_SEARCH = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // Command payload
    typedef struct packed {
        t_opcode                    opcode;
        logic [POS_W-1:0]           position;
        logic signed [COORD_W-1:0]  data_x;
        logic signed [COORD_W-1:0]  data_y;
    } t_in_item;

    // Result payload
    typedef struct packed {
        t_status                    status;
        logic                       found;
        logic signed [COORD_W-1:0]  out_x;
        logic signed [COORD_W-1:0]  out_y;
        logic [CNT_W-1:0]           count;
    } t_out_item;

    // Per-cell control from the queue controller
    typedef struct packed {
        logic take_new;    // load the incoming pair
        logic take_left;   // shift toward the tail: load from the cell before
        logic take_right;  // shift toward the head: load from the cell after
        logic cmp_en;      // compare the stored pair against the key
    } t_cell_ctl;

endpackage

### sv/pisq_cell.sv
// One storage cell of the queue: holds a pair, shifts either way, compares.
module pisq_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pisq_pkg::t_cell_ctl          i_ctl,
    input  logic [pisq_pkg::WORD_W-1:0]  i_new,
    input  logic [pisq_pkg::WORD_W-1:0]  i_left,
    input  logic [pisq_pkg::WORD_W-1:0]  i_right,
    output logic [pisq_pkg::WORD_W-1:0]  o_data,
    output logic                         o_match
);
    import pisq_pkg::*;

    logic [WORD_W-1:0] r_data;
    logic              r_match;

    // Stored pair: load new, shift back, or shift forward
    always_ff @(posedge i_clk) begin
        if (i_ctl.take_new) begin
            r_data <= i_new;
        end else if (i_ctl.take_left) begin
            r_data <= i_left;
        end else if (i_ctl.take_right) begin
            r_data <= i_right;
        end
    end

    // Registered compare against the search key
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else begin
            r_match <= i_ctl.cmp_en && (r_data == i_new);
        end
    end

    assign o_data  = r_data;
    assign o_match = r_match;

endmodule

### sv/positional_insert_search_queue_unit.sv
// Top level: ordered pair queue with append, positional insert, remove, search.
//
//  channel   direction  handshake                     payload
//  command   in         i_start, accepted when !o_busy  i_item   (t_in_item)
//  result    out        o_strobe, one cycle             o_result (t_out_item)
//
// Each command gives one result: the first register stage updates the cell row
// and registers the per-cell compare, the output register then ORs the compare
// flags across the row. A new command may follow every cycle while o_busy is low.
// o_busy is high during reset and the cycle after it.
// Results cannot be stalled; the strobe is a single cycle.
// Count reports the low 5 bits of the number of stored entries.
module positional_insert_search_queue_unit #(
    parameter int unsigned DEPTH = pisq_pkg::DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  pisq_pkg::t_in_item   i_item,
    output logic                 o_busy,
    output logic                 o_strobe,
    output pisq_pkg::t_out_item  o_result
);
    import pisq_pkg::*;

    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;

    logic                  r_ready;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic                  accept;
    logic [PW-1:0]         pos_w;
    logic [PW-1:0]         cnt_w;
    logic [PW-1:0]         put_pos;
    logic                  do_put;
    logic                  do_pop;
    logic                  is_full;
    t_status               status;
    logic [WORD_W-1:0]     key;
    logic [WORD_W-1:0]     cell_data [DEPTH];
    logic [DEPTH-1:0]      cell_match;

    // First stage of the result
    logic                  r_pend;
    logic                  r_pend_search;
    t_status               r_pend_status;
    logic [COORD_W-1:0]    r_pend_x;
    logic [COORD_W-1:0]    r_pend_y;
    logic [CNT_W-1:0]      r_pend_count;

    // Output register
    logic                  r_strobe;
    t_out_item             r_out;

    assign accept  = i_start && r_ready;
    assign o_busy  = !r_ready;
    assign pos_w   = PW'(i_item.position);
    assign cnt_w   = PW'(r_count);
    assign is_full = (r_count == CW'(DEPTH));
    assign key     = {i_item.data_y, i_item.data_x};

    // Command decode
    always_comb begin
        do_put  = 1'b0;
        do_pop  = 1'b0;
        put_pos = cnt_w;
        status  = ST_OK;
        unique case (i_item.opcode)
            OP_APPEND: begin
                if (is_full) begin
                    status = ST_FULL;
                end else begin
                    do_put = accept;
                end
            end
            OP_INSERT: begin
                put_pos = pos_w;
                if (pos_w > cnt_w) begin
                    status = ST_RANGE;
                end else if (is_full) begin
                    status = ST_FULL;
                end else begin
                    do_put = accept;
                end
            end
            OP_REMOVE: begin
                if (r_count == '0) begin
                    status = ST_EMPTY;
                end else begin
                    do_pop = accept;
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase
    end

    // Next entry count
    always_comb begin
        n_count = r_count;
        if (do_put) begin
            n_count = r_count + CW'(1);
        end else if (do_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    // Row of cells, head at index 0
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        localparam logic [PW-1:0] IDX  = PW'(gi);
        localparam logic [PW:0]   IDX1 = (PW + 1)'(gi + 1);
        t_cell_ctl         ctl;
        logic [WORD_W-1:0] left_d;
        logic [WORD_W-1:0] right_d;

        always_comb begin
            ctl.take_new   = do_put && (IDX == put_pos);
            ctl.take_left  = (gi != 0) && do_put && (IDX > put_pos) && (IDX <= cnt_w);
            ctl.take_right = (gi != DEPTH - 1) && do_pop && (IDX1 < {1'b0, cnt_w});
            ctl.cmp_en     = accept && (i_item.opcode == OP_SEARCH) && (IDX < cnt_w);
        end

        if (gi == 0) begin : g_head
            assign left_d = key;
        end else begin : g_mid_l
            assign left_d = cell_data[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_tail
            assign right_d = cell_data[gi];
        end else begin : g_mid_r
            assign right_d = cell_data[gi+1];
        end

        pisq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_new   (key),
            .i_left  (left_d),
            .i_right (right_d),
            .o_data  (cell_data[gi]),
            .o_match (cell_match[gi])
        );
    end

    // Control state: ready flag, entry count and pending-result flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_ready <= 1'b1;
            r_count <= n_count;
            r_pend  <= accept;
        end
    end

    // First result stage: everything but the search outcome
    always_ff @(posedge i_clk) begin
        r_pend_search <= (i_item.opcode == OP_SEARCH);
        r_pend_status <= status;
        r_pend_x      <= do_pop ? cell_data[0][COORD_W-1:0] : '0;
        r_pend_y      <= do_pop ? cell_data[0][WORD_W-1:COORD_W] : '0;
        r_pend_count  <= CNT_W'(n_count);
    end

    // Output register: fold in the OR of the cell compares
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out.status <= r_pend_status;
        r_out.found  <= r_pend_search && (|cell_match);
        r_out.out_x  <= r_pend_x;
        r_out.out_y  <= r_pend_y;
        r_out.count  <= r_pend_count;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

### sv/pisq_checker.sv
// Checker: port-level properties of the queue unit, bound to the top level.
module pisq_checker #(
    parameter int unsigned DEPTH = pisq_pkg::DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  pisq_pkg::t_in_item   i_item,
    input  logic                 o_busy,
    input  logic                 o_strobe,
    input  pisq_pkg::t_out_item  o_result
);
    import pisq_pkg::*;

    logic accept;
    assign accept = i_start && !o_busy;

    // Every command transfer yields a result strobe
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##2 o_strobe)
        else $error("missing result after command transfer");

    // No result without an earlier command transfer
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(accept, 2))
        else $error("result without a command");

    // A hit only on a successful search, with no popped pair
    a_found_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.found) |->
            (o_result.status == ST_OK && o_result.out_x == '0 && o_result.out_y == '0))
        else $error("found set on a non-search result");

    // Empty remove reports an empty queue and zero coordinates
    a_empty_remove: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status == ST_EMPTY) |->
            (o_result.count == '0 && o_result.out_x == '0 && o_result.out_y == '0))
        else $error("empty remove with nonzero payload");

    // Reported count never exceeds the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ((DEPTH > 31) || (32'(o_result.count) <= DEPTH)))
        else $error("count exceeds capacity");

endmodule

bind positional_insert_search_queue_unit pisq_checker #(.DEPTH(DEPTH)) u_pisq_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .i_item   (i_item),
    .o_busy   (o_busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

### sim/tb_positional_insert_search_queue_unit.sv
// Testbench: self-checking random and directed test of the positional insert search queue.
module tb_positional_insert_search_queue_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import pisq_pkg::*;

    localparam int unsigned QDEPTH      = DEPTH_DEF;
    localparam int          RAND_ITEMS  = 1500;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          DRAIN_WAIT  = 8;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_start;
    t_in_item   i_item;
    logic       o_busy;
    logic       o_strobe;
    t_out_item  o_result;

    positional_insert_search_queue_unit #(
        .DEPTH(QDEPTH)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_item   (i_item),
        .o_busy   (o_busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // Commands waiting to be driven, and results owed by the block
    t_in_item   cmd_backlog[$];
    t_out_item  owed_results[$];

    // Shadow of the queue contents: x in the low half, y in the high half
    logic [WORD_W-1:0] shadow_pairs[QDEPTH];
    int                shadow_count = 0;

    int  mismatch_count = 0;
    int  cycle_count    = 0;
    int  idle_left      = 0;
    bit  steady_mode    = 1'b0;
    int  gen_count      = 0;

    logic signed [COORD_W-1:0] pool_x[8];
    logic signed [COORD_W-1:0] pool_y[8];

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Apply one command to the shadow queue and return the result it owes
    function automatic t_out_item apply_queue_op(t_in_item cmd);
        t_out_item         res;
        logic [WORD_W-1:0] word;
        int                slot;
        int                i;
        res        = '0;
        res.status = ST_OK;
        word       = {cmd.data_y, cmd.data_x};
        case (cmd.opcode)
            OP_APPEND, OP_INSERT: begin
                slot = (cmd.opcode == OP_APPEND) ? shadow_count : int'(cmd.position);
                if (slot > shadow_count) begin
                    res.status = ST_RANGE;
                end else if (shadow_count >= QDEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    for (i = shadow_count; i > slot; i--)
                        shadow_pairs[i] = shadow_pairs[i-1];
                    shadow_pairs[slot] = word;
                    shadow_count++;
                end
            end
            OP_REMOVE: begin
                if (shadow_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.out_x = shadow_pairs[0][COORD_W-1:0];
                    res.out_y = shadow_pairs[0][WORD_W-1:COORD_W];
                    for (i = 1; i < shadow_count; i++)
                        shadow_pairs[i-1] = shadow_pairs[i];
                    shadow_count--;
                end
            end
            default: begin
                for (i = 0; i < shadow_count; i++)
                    if (shadow_pairs[i] == word)
                        res.found = 1'b1;
            end
        endcase
        res.count = CNT_W'(shadow_count);
        return res;
    endfunction

    // Coordinate with a bias toward the extremes
    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 11))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    // Queue a command and track the occupancy it leaves behind
    task automatic push_cmd(t_opcode op, int pos, logic [COORD_W-1:0] x,
                            logic [COORD_W-1:0] y);
        t_in_item cmd;
        cmd.opcode   = op;
        cmd.position = POS_W'(pos);
        cmd.data_x   = x;
        cmd.data_y   = y;
        cmd_backlog.push_back(cmd);
        case (op)
            OP_APPEND: if (gen_count < QDEPTH) gen_count++;
            OP_INSERT: if (pos <= gen_count && gen_count < QDEPTH) gen_count++;
            OP_REMOVE: if (gen_count > 0) gen_count--;
            default: ;
        endcase
    endtask

    // Mismatch report
    task automatic report_mismatch(string fld, logic [63:0] exp_val, logic [63:0] act_val);
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, fld, exp_val, act_val);
        mismatch_count++;
    endtask

    // Driver: hold each command until its transfer, with random gaps between
    always @(posedge i_clk) begin
        logic [95:0] noise;
        noise = {$urandom(), $urandom(), $urandom()};
        if (!i_rst_n) begin
            i_start <= 1'b0;
            i_item  <= '0;
        end else begin
            if (i_start && !o_busy)
                owed_results.push_back(apply_queue_op(i_item));
            if (!i_start || !o_busy) begin
                if (idle_left > 0) begin
                    idle_left--;
                    i_start <= 1'b0;
                    i_item  <= noise[$bits(t_in_item)-1:0];
                end else if (cmd_backlog.size() != 0) begin
                    i_start <= 1'b1;
                    i_item  <= cmd_backlog.pop_front();
                    if ($urandom_range(0, 49) == 0)
                        steady_mode = !steady_mode;
                    idle_left = steady_mode ? 0 : $urandom_range(0, 9);
                end else begin
                    i_start <= 1'b0;
                    i_item  <= noise[$bits(t_in_item)-1:0];
                end
            end
        end
    end

    // Monitor: every strobed result against the oldest owed one
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_strobe !== 1'b0) begin
            if (owed_results.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, actual %0h",
                         $time, o_result);
                mismatch_count++;
            end else begin
                want = owed_results.pop_front();
                if (o_result.status !== want.status)
                    report_mismatch("status", 64'(want.status), 64'(o_result.status));
                if (o_result.found !== want.found)
                    report_mismatch("found", 64'(want.found), 64'(o_result.found));
                if (o_result.out_x !== want.out_x)
                    report_mismatch("out_x", 64'(unsigned'(want.out_x)),
                                    64'(unsigned'(o_result.out_x)));
                if (o_result.out_y !== want.out_y)
                    report_mismatch("out_y", 64'(unsigned'(want.out_y)),
                                    64'(unsigned'(o_result.out_y)));
                if (o_result.count !== want.count)
                    report_mismatch("count", 64'(want.count), 64'(o_result.count));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("positional_insert_search_queue_unit verification failed");
            $finish;
        end
    end

    // Stimulus and end of test
    initial begin
        int      n;
        int      k;
        int      j;
        int      sel;
        int      bias;
        int      pos;
        t_opcode op;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;

        i_rst_n <= 1'b0;
        i_start <= 1'b0;
        i_item  <= '0;

        // Directed: empty cases, out-of-range insert, extremes, ordering, search hit and miss, full cases
        push_cmd(OP_REMOVE, 0, 32'h0, 32'h0);
        push_cmd(OP_SEARCH, 0, 32'h0, 32'h0);
        push_cmd(OP_INSERT, 1, 32'h1, 32'h2);
        push_cmd(OP_INSERT, 0, 32'h5, 32'h6);
        push_cmd(OP_APPEND, 16, 32'h8000_0000, 32'h7fff_ffff);
        push_cmd(OP_APPEND, 0, 32'h7fff_ffff, 32'h8000_0000);
        push_cmd(OP_APPEND, 0, 32'h0, 32'hffff_ffff);
        push_cmd(OP_APPEND, 0, 32'hffff_ffff, 32'h0);
        push_cmd(OP_INSERT, 5, 32'h7, 32'h8);
        push_cmd(OP_INSERT, 2, 32'h9, 32'ha);
        push_cmd(OP_SEARCH, 0, 32'h8000_0000, 32'h7fff_ffff);
        push_cmd(OP_SEARCH, 0, 32'h8000_0000, 32'h7fff_fffe);
        push_cmd(OP_SEARCH, 0, 32'hffff_ffff, 32'h0);
        for (n = 0; n < 9; n++)
            push_cmd(OP_APPEND, 0, rand_coord(), rand_coord());
        push_cmd(OP_APPEND, 0, 32'h3, 32'h4);
        push_cmd(OP_INSERT, 16, 32'h3, 32'h4);
        push_cmd(OP_INSERT, 0, 32'h3, 32'h4);
        push_cmd(OP_SEARCH, 0, 32'h5, 32'h6);
        push_cmd(OP_REMOVE, 0, 32'h0, 32'h0);

        // Random: phases that lean toward filling, balance or draining
        bias = 1;
        for (n = 0; n < RAND_ITEMS; n++) begin
            if (n % 200 == 0) begin
                for (k = 0; k < 4; k++) begin
                    pool_x[k]   = rand_coord();
                    pool_y[k]   = rand_coord();
                    pool_x[k+4] = pool_x[k];     // same x, other y
                    pool_y[k+4] = rand_coord();
                end
            end
            if (n % 60 == 0)
                bias = $urandom_range(0, 2);
            sel = $urandom_range(0, 99);
            case (bias)
                0:       op = (sel < 10) ? OP_APPEND : (sel < 20) ? OP_INSERT :
                              (sel < 70) ? OP_REMOVE : OP_SEARCH;
                1:       op = (sel < 20) ? OP_APPEND : (sel < 45) ? OP_INSERT :
                              (sel < 70) ? OP_REMOVE : OP_SEARCH;
                default: op = (sel < 35) ? OP_APPEND : (sel < 70) ? OP_INSERT :
                              (sel < 80) ? OP_REMOVE : OP_SEARCH;
            endcase
            // Mostly legal positions, some one past the count, some anywhere
            sel = $urandom_range(0, 9);
            if (op != OP_INSERT || sel == 9)
                pos = $urandom_range(0, 16);
            else if (sel < 8)
                pos = $urandom_range(0, gen_count);
            else
                pos = (gen_count < 16) ? gen_count + 1 : 16;
            k = $urandom_range(0, 7);
            j = $urandom_range(0, 7);
            sel = $urandom_range(0, 9);
            if (sel < 6) begin
                x = pool_x[k];
                y = pool_y[k];
            end else if (sel < 8) begin
                x = pool_x[k];
                y = pool_y[j];
            end else begin
                x = rand_coord();
                y = rand_coord();
            end
            push_cmd(op, pos, x, y);
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain, then let any stray result show up
        do
            @(negedge i_clk);
        while (cmd_backlog.size() != 0 || i_start || owed_results.size() != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("positional_insert_search_queue_unit verification clean");
        end else begin
            $display("positional_insert_search_queue_unit verification failed");
        end
        $finish;
    end

endmodule
